// ===== rtl/assert_macros.svh =====
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define MFC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define MFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MFC_ASSERT(lbl, clk, rst, prop, msg)
`define MFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/mfc_pkg.sv =====
package mfc_pkg;

   // request operation codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_TABLE = 1'b1;

   // frame format constants
   localparam logic [7:0]  MAGIC_V2   = 8'hFD;
   localparam logic [8:0]  HDR_V1     = 9'd6;
   localparam logic [8:0]  HDR_V2     = 9'd10;
   localparam logic [8:0]  CRC_BYTES  = 9'd2;
   localparam logic [8:0]  SIG_BYTES  = 9'd13;
   localparam logic [8:0]  FRAME_MIN  = 9'd8;
   localparam logic [8:0]  FRAME_MAX  = 9'd280;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [23:0] MSGID_MASK = 24'hFFFFFF;

   typedef enum logic [1:0] {
      KIND_OK      = 2'd0,
      KIND_BAD_CRC = 2'd1,
      KIND_UNKNOWN = 2'd2
   } frame_kind_type;

   typedef struct packed {
      logic       func;
      logic [7:0] frame_byte;
      logic [8:0] entry_index;
      logic       entry_known;
      logic [7:0] entry_extra;
   } mfc_req_type;

   typedef struct packed {
      frame_kind_type frame_kind;
      logic           is_version2;
      logic           is_signed;
      logic [7:0]     payload_length;
      logic [7:0]     sequence_res;
      logic [7:0]     system_id;
      logic [7:0]     component_id;
      logic [23:0]    message_id;
      logic [7:0]     crc_extra;
      logic           extra_valid;
      logic [8:0]     frame_size;
   } mfc_rsp_type;

   // header fields gathered while the frame streams in
   typedef struct packed {
      logic [23:0] msg_id;
      logic [7:0]  comp;
      logic [7:0]  sys;
      logic [7:0]  seq;
      logic [7:0]  len;
   } mfc_hdr_type;

   // one message table entry
   typedef struct packed {
      logic       known;
      logic [7:0] extra;
   } mfc_entry_type;

   // summary of a finished frame handed to the check stage
   typedef struct packed {
      logic [15:0] crc_running;
      logic [15:0] crc_received;
      mfc_hdr_type hdr;
      logic        version2;
      logic        signed_flag;
      logic [8:0]  frame_total;
   } mfc_done_type;

   // reflected crc-16 update by one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = {8'h00, crc[7:0] ^ b};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return {8'h00, crc[15:8]} ^ v;
   endfunction

endpackage

// ===== rtl/mfc_frame_tracker.sv =====
module mfc_frame_tracker
   import mfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_en,
   input  logic [7:0]   byte_in,
   output logic         idle,
   output mfc_hdr_type  hdr,
   output logic         done,
   output mfc_done_type done_info
);

   logic [8:0]  pos_ff, pos_in;
   logic [8:0]  total_ff, total_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcv_ff, rcv_in;
   logic        v2_ff, v2_in;
   logic        sgn_ff, sgn_in;
   mfc_hdr_type hdr_ff, hdr_in;

   logic [8:0]  hsz;
   logic [8:0]  len9;
   logic [8:0]  crc_pos;
   logic [9:0]  next_pos;

   // per-byte state update
   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      v2_in    = v2_ff;
      sgn_in   = sgn_ff;
      hdr_in   = hdr_ff;
      done     = 1'b0;
      hsz      = v2_ff ? HDR_V2 : HDR_V1;
      len9     = (pos_ff == 9'd1) ? {1'b0, byte_in} : {1'b0, hdr_ff.len};
      crc_pos  = hsz + len9;
      next_pos = {1'b0, pos_ff} + 10'd1;
      if (byte_en) begin
         if (pos_ff == 9'd0) begin
            // start of frame
            v2_in    = (byte_in == MAGIC_V2);
            sgn_in   = 1'b0;
            crc_in   = CRC_SEED;
            rcv_in   = 16'h0000;
            hdr_in   = '0;
            total_in = 9'd0;
            pos_in   = 9'd1;
         end else begin
            if (pos_ff == 9'd1) begin
               hdr_in.len = byte_in;
               total_in   = crc_pos + CRC_BYTES;
            end
            if (pos_ff < crc_pos) begin
               crc_in = crc_byte(crc_ff, byte_in);
               if (v2_ff) begin
                  case (pos_ff)
                     9'd2: begin
                        if (byte_in[0]) begin
                           sgn_in   = 1'b1;
                           total_in = total_in + SIG_BYTES;
                        end
                     end
                     9'd4: hdr_in.seq = byte_in;
                     9'd5: hdr_in.sys = byte_in;
                     9'd6: hdr_in.comp = byte_in;
                     9'd7: hdr_in.msg_id[7:0] = byte_in;
                     9'd8: hdr_in.msg_id[15:8] = byte_in;
                     9'd9: hdr_in.msg_id[23:16] = byte_in;
                     default: ;
                  endcase
               end else begin
                  case (pos_ff)
                     9'd2: hdr_in.seq = byte_in;
                     9'd3: hdr_in.sys = byte_in;
                     9'd4: hdr_in.comp = byte_in;
                     9'd5: hdr_in.msg_id[7:0] = byte_in;
                     default: ;
                  endcase
               end
            end else if (pos_ff == crc_pos) begin
               rcv_in = {8'h00, byte_in};
            end else if (pos_ff == crc_pos + 9'd1) begin
               rcv_in = {byte_in, rcv_ff[7:0]};
            end
            // end of frame detection
            if (next_pos < {1'b0, total_in}) begin
               pos_in = next_pos[8:0];
            end else begin
               pos_in = 9'd0;
               done   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 9'd0;
         total_ff <= 9'd0;
         crc_ff   <= CRC_SEED;
         rcv_ff   <= 16'h0000;
         v2_ff    <= 1'b0;
         sgn_ff   <= 1'b0;
         hdr_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
         v2_ff    <= v2_in;
         sgn_ff   <= sgn_in;
         hdr_ff   <= hdr_in;
      end
   end

   // frame summary from the updated values
   always_comb begin
      done_info.crc_running  = crc_in;
      done_info.crc_received = rcv_in;
      done_info.hdr          = hdr_in;
      done_info.version2     = v2_ff;
      done_info.signed_flag  = sgn_in;
      done_info.frame_total  = total_in;
   end

   assign idle = (pos_ff == 9'd0);
   assign hdr  = hdr_ff;

endmodule

// ===== rtl/mfc_msg_table.sv =====
module mfc_msg_table
   import mfc_pkg::*;
#(
   parameter int TABLE_DEPTH = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [8:0]    wr_index,
   input  mfc_entry_type wr_entry,
   input  logic [23:0]   rd_id,
   output logic          busy,
   output mfc_entry_type rd_entry
);

   localparam int AW = $clog2(TABLE_DEPTH);

   mfc_entry_type mem [TABLE_DEPTH];

   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   mfc_entry_type rd_q_ff;
   logic          rd_range_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   mfc_entry_type mem_wdata;
   logic          wr_in_range;

   // clearing pass after reset, one entry a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared by clearing pass and entry loads
   always_comb begin
      wr_in_range = (32'(wr_index) < 32'(TABLE_DEPTH));
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr_en && wr_in_range;
         mem_waddr = AW'(wr_index);
         mem_wdata = wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff     <= mem[rd_id[AW-1:0]];
      rd_range_ff <= (rd_id < 24'(TABLE_DEPTH));
   end

   // ids beyond the table read as unknown
   always_comb begin
      rd_entry.known = rd_range_ff && rd_q_ff.known;
      rd_entry.extra = rd_range_ff ? rd_q_ff.extra : 8'h00;
   end

   assign busy = clr_busy_ff;

endmodule

// ===== rtl/mfc_crc_eval.sv =====
module mfc_crc_eval
   import mfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  mfc_done_type  done_info,
   input  mfc_entry_type entry,
   output logic          can_load,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output mfc_rsp_type   rsp_data
);

   logic          ev_valid_ff, ev_valid_in;
   mfc_done_type  ev_info_ff;
   mfc_entry_type ev_entry_ff;
   logic          out_valid_ff, out_valid_in;
   mfc_rsp_type   out_ff, out_in;

   logic          out_free;
   logic          ev_adv;
   logic [15:0]   crc_fold;
   logic [15:0]   mixed;
   logic [7:0]    hi;
   logic [7:0]    x;
   logic [7:0]    lo;

   // stage flow control
   assign out_free = !out_valid_ff || rsp_ready;
   assign ev_adv   = ev_valid_ff && out_free;
   assign can_load = !ev_valid_ff || out_free;

   always_comb begin
      ev_valid_in = ev_valid_ff;
      if (load) begin
         ev_valid_in = 1'b1;
      end else if (ev_adv) begin
         ev_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (ev_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // crc check against table extra, or solve for the extra
   always_comb begin
      crc_fold = crc_byte(ev_info_ff.crc_running, ev_entry_ff.extra);
      mixed    = ev_info_ff.crc_received ^ {8'h00, ev_info_ff.crc_running[15:8]};
      hi       = mixed[15:8];
      x        = hi ^ {5'b00000, hi[7:5]};
      lo       = {x[4:0], 3'b000} ^ {4'h0, x[7:4]};

      out_in.is_version2    = ev_info_ff.version2;
      out_in.is_signed      = ev_info_ff.version2 && ev_info_ff.signed_flag;
      out_in.payload_length = ev_info_ff.hdr.len;
      out_in.sequence_res   = ev_info_ff.hdr.seq;
      out_in.system_id      = ev_info_ff.hdr.sys;
      out_in.component_id   = ev_info_ff.hdr.comp;
      out_in.message_id     = ev_info_ff.hdr.msg_id & MSGID_MASK;
      out_in.frame_size     = ev_info_ff.frame_total;

      if (ev_entry_ff.known) begin
         out_in.frame_kind  = (crc_fold == ev_info_ff.crc_received) ? KIND_OK : KIND_BAD_CRC;
         out_in.crc_extra   = ev_entry_ff.extra;
         out_in.extra_valid = 1'b1;
      end else if (lo == mixed[7:0]) begin
         out_in.frame_kind  = KIND_UNKNOWN;
         out_in.crc_extra   = x ^ {x[3:0], 4'h0} ^ ev_info_ff.crc_running[7:0];
         out_in.extra_valid = 1'b1;
      end else begin
         out_in.frame_kind  = KIND_BAD_CRC;
         out_in.crc_extra   = 8'h00;
         out_in.extra_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         ev_info_ff  <= done_info;
         ev_entry_ff <= entry;
      end
      if (ev_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/mavlink_frame_checker_unit.sv =====
// frame checker: one frame byte or table write per cycle, back to back while req_ready is high
// result path: the frame summary passes the eval register, then the output register, before rsp_valid
// throughput: one transaction per cycle while req_ready is high, set by the byte-wide crc update
// reset: synchronous, active high; clears frame state and result stages
// after reset the message table is cleared one entry a cycle, all TABLE_DEPTH
// entries (512 by default), with req_ready low until the clearing pass ends
module mavlink_frame_checker_unit
   import mfc_pkg::*;
#(
   parameter int TABLE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mfc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mfc_rsp_type rsp_data
);

`include "assert_macros.svh"

   logic          req_fire;
   logic          byte_en;
   logic          tbl_wr;
   logic          trk_idle;
   mfc_hdr_type   trk_hdr;
   logic          frame_done;
   mfc_done_type  done_info;
   logic          tbl_busy;
   mfc_entry_type wr_entry;
   mfc_entry_type rd_entry;
   logic          can_load;
   logic          size_ok;
   logic          kind_ok;

   // request transaction steering
   assign req_ready = !tbl_busy && can_load;
   assign req_fire  = req_valid && req_ready;
   assign byte_en   = req_fire && (req_data.func == FUNC_BYTE);
   assign tbl_wr    = req_fire && (req_data.func == FUNC_TABLE) && trk_idle;

   assign wr_entry.known = req_data.entry_known;
   assign wr_entry.extra = req_data.entry_extra;

   mfc_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .byte_in   (req_data.frame_byte),
      .idle      (trk_idle),
      .hdr       (trk_hdr),
      .done      (frame_done),
      .done_info (done_info)
   );

   mfc_msg_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr),
      .wr_index (req_data.entry_index),
      .wr_entry (wr_entry),
      .rd_id    (trk_hdr.msg_id),
      .busy     (tbl_busy),
      .rd_entry (rd_entry)
   );

   mfc_crc_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .load      (frame_done),
      .done_info (done_info),
      .entry     (rd_entry),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // checks
   assign size_ok = (rsp_data.frame_size >= FRAME_MIN) && (rsp_data.frame_size <= FRAME_MAX);
   assign kind_ok = rsp_data.extra_valid || (rsp_data.frame_kind == KIND_BAD_CRC);

   `MFC_ASSERT_NEXT(a_clear_once, clock, reset, !tbl_busy, !tbl_busy, "table clear restarted")
   `MFC_ASSERT(a_size_range, clock, reset, rsp_valid |-> size_ok, "frame size out of range")
   `MFC_ASSERT(a_no_extra_bad, clock, reset, rsp_valid |-> kind_ok, "extra missing, crc not bad")

endmodule

// ===== bench/frame_result_monitor.sv =====
module frame_result_monitor
   import mfc_pkg::*;
#(
   parameter int TABLE_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  mfc_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  mfc_rsp_type rsp_data,
   output int          fail_count,
   output int          outstanding,
   output int          frames_ok,
   output int          frames_bad,
   output int          frames_unknown
);

   // shadow of the frame parser
   logic [8:0]    byte_pos;
   logic [8:0]    frame_total;
   logic [15:0]   crc_run;
   logic [15:0]   crc_rx;
   logic          ver2;
   logic          sig;
   mfc_hdr_type   hdr;
   mfc_entry_type msg_table [TABLE_DEPTH];

   // frame results still owed by the block, oldest first
   mfc_rsp_type   expected_verdicts [$];

   // reflected crc-16, one byte at a time
   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] w;
      w = {8'h00, acc[7:0] ^ d};
      repeat (8) w = w[0] ? ((w >> 1) ^ CRC_POLY) : (w >> 1);
      return {8'h00, acc[15:8]} ^ w;
   endfunction

   task automatic check_field(input string what, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   // step the parser by one accepted transaction, queue a result at frame end
   task automatic advance_parse(input mfc_req_type t);
      int            p, hlen, plen, crc_at;
      logic [7:0]    b, hi, x, lo;
      logic [15:0]   mixed;
      mfc_entry_type e;
      mfc_rsp_type   r;
      // table writes land only between frames
      if (t.func == FUNC_TABLE) begin
         if (byte_pos == 0 && t.entry_index < TABLE_DEPTH)
            msg_table[t.entry_index] = {t.entry_known, t.entry_extra};
         return;
      end
      b = t.frame_byte;
      p = byte_pos;
      // first byte picks the version and restarts the frame
      if (p == 0) begin
         ver2        = (b == MAGIC_V2);
         sig         = 1'b0;
         crc_run     = CRC_SEED;
         crc_rx      = '0;
         hdr         = '0;
         frame_total = '0;
         byte_pos    = 9'd1;
         return;
      end
      hlen = ver2 ? HDR_V2 : HDR_V1;
      plen = hdr.len;
      if (p == 1) begin
         plen        = b;
         hdr.len     = b;
         frame_total = 9'(hlen + plen + CRC_BYTES);
      end
      crc_at = hlen + plen;
      // header and payload go through the crc, then the crc bytes low first
      if (p < crc_at) begin
         crc_run = crc_fold(crc_run, b);
         if (ver2) begin
            if (p == 2 && b[0]) begin
               sig         = 1'b1;
               frame_total = frame_total + SIG_BYTES;
            end
            else if (p == 4) hdr.seq = b;
            else if (p == 5) hdr.sys = b;
            else if (p == 6) hdr.comp = b;
            else if (p >= 7 && p <= 9) hdr.msg_id[8*(p-7) +: 8] = b;
         end else begin
            case (p)
               2: hdr.seq = b;
               3: hdr.sys = b;
               4: hdr.comp = b;
               5: hdr.msg_id[7:0] = b;
               default: ;
            endcase
         end
      end
      else if (p == crc_at) crc_rx = {8'h00, b};
      else if (p == crc_at + 1) crc_rx[15:8] = b;
      if (p + 1 < frame_total) begin
         byte_pos = 9'(p + 1);
         return;
      end
      byte_pos = '0;

      // known ids check against their extra, unknown ids solve for one
      e = '0;
      if (hdr.msg_id < TABLE_DEPTH) e = msg_table[hdr.msg_id];
      r.is_version2    = ver2;
      r.is_signed      = ver2 && sig;
      r.payload_length = hdr.len;
      r.sequence_res   = hdr.seq;
      r.system_id      = hdr.sys;
      r.component_id   = hdr.comp;
      r.message_id     = hdr.msg_id;
      r.frame_size     = frame_total;
      if (e.known) begin
         r.frame_kind  = (crc_fold(crc_run, e.extra) == crc_rx) ? KIND_OK : KIND_BAD_CRC;
         r.crc_extra   = e.extra;
         r.extra_valid = 1'b1;
      end else begin
         mixed = crc_rx ^ {8'h00, crc_run[15:8]};
         hi    = mixed[15:8];
         x     = hi ^ (hi >> 5);
         lo    = (x << 3) ^ (x >> 4);
         if (lo == mixed[7:0]) begin
            r.frame_kind  = KIND_UNKNOWN;
            r.crc_extra   = x ^ (x << 4) ^ crc_run[7:0];
            r.extra_valid = 1'b1;
         end else begin
            r.frame_kind  = KIND_BAD_CRC;
            r.crc_extra   = '0;
            r.extra_valid = 1'b0;
         end
      end
      expected_verdicts.push_back(r);
   endtask

   // compare one accepted result with the oldest expectation
   task automatic score_result(input mfc_rsp_type got);
      mfc_rsp_type want;
      if (expected_verdicts.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected frame result, expected none, got 0x%h", $time, got);
         return;
      end
      want = expected_verdicts.pop_front();
      check_field("frame_kind", want.frame_kind, got.frame_kind);
      check_field("is_version2", want.is_version2, got.is_version2);
      check_field("is_signed", want.is_signed, got.is_signed);
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("sequence_res", want.sequence_res, got.sequence_res);
      check_field("system_id", want.system_id, got.system_id);
      check_field("component_id", want.component_id, got.component_id);
      check_field("message_id", want.message_id, got.message_id);
      check_field("crc_extra", want.crc_extra, got.crc_extra);
      check_field("extra_valid", want.extra_valid, got.extra_valid);
      check_field("frame_size", want.frame_size, got.frame_size);
      case (want.frame_kind)
         KIND_OK:      frames_ok++;
         KIND_BAD_CRC: frames_bad++;
         default:      frames_unknown++;
      endcase
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         byte_pos    = '0;
         frame_total = '0;
         crc_run     = CRC_SEED;
         crc_rx      = '0;
         ver2        = 1'b0;
         sig         = 1'b0;
         hdr         = '0;
         foreach (msg_table[i]) msg_table[i] = '0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) score_result(rsp_data);
         if (req_valid && req_ready) advance_parse(req_data);
      end
      outstanding = expected_verdicts.size();
   end

endmodule

// ===== bench/tb.sv =====
module tb;
   import mfc_pkg::*;

   localparam int TABLE_DEPTH     = 512;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS    = 1000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   mfc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   mfc_rsp_type rsp_data;

   int fail_count, outstanding, frames_ok, frames_bad, frames_unknown;
   int send_idle_pct = 30;
   int recv_idle_pct = 76;
   int sent_count    = 0;
   int table_writes  = 0;
   int cycle_count   = 0;
   int base;
   bit hold_off_pending = 1'b0;

   // what the stimulus believes the table holds, for building good crcs
   logic       shadow_known [TABLE_DEPTH] = '{default: 1'b0};
   logic [7:0] shadow_extra [TABLE_DEPTH] = '{default: 8'h00};
   logic [8:0] known_ids [$];

   mavlink_frame_checker_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   frame_result_monitor #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_result_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .frames_ok     (frames_ok),
      .frames_bad    (frames_bad),
      .frames_unknown(frames_unknown)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crc for building frames on the stimulus side
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] w;
      w = {8'h00, acc[7:0] ^ d};
      repeat (8) w = w[0] ? ((w >> 1) ^ CRC_POLY) : (w >> 1);
      return {8'h00, acc[15:8]} ^ w;
   endfunction

   // extra byte to fold: the table one if known, otherwise anything
   function automatic logic [7:0] fold_for(input logic [23:0] id);
      if (id < TABLE_DEPTH && shadow_known[id]) return shadow_extra[id];
      return 8'($urandom);
   endfunction

   // present one transaction and hold it until accepted
   task automatic offer(input mfc_req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      mfc_req_type t;
      t.func        = FUNC_BYTE;
      t.frame_byte  = b;
      t.entry_index = 9'($urandom);
      t.entry_known = 1'($urandom);
      t.entry_extra = 8'($urandom);
      offer(t);
   endtask

   task automatic write_entry(input logic [8:0] idx, input logic known,
                              input logic [7:0] extra);
      mfc_req_type t;
      t.func        = FUNC_TABLE;
      t.frame_byte  = 8'($urandom);
      t.entry_index = idx;
      t.entry_known = known;
      t.entry_extra = extra;
      offer(t);
      table_writes++;
      shadow_known[idx] = known;
      shadow_extra[idx] = extra;
      if (known) known_ids.push_back(idx);
   endtask

   // build a whole frame, optionally break its crc or slip a table write inside
   task automatic send_frame(input logic v2, input logic [7:0] lead,
                             input logic [7:0] incompat, input logic [7:0] plen,
                             input logic [23:0] id, input logic corrupt,
                             input logic mid_write);
      logic [7:0]  body [$];
      logic [15:0] crc;
      logic [23:0] fid;
      int          wr_at;
      mfc_req_type w;
      fid = v2 ? id : {16'h0000, id[7:0]};
      body.push_back(v2 ? MAGIC_V2 : lead);
      body.push_back(plen);
      if (v2) begin
         body.push_back(incompat);
         body.push_back(8'($urandom));
      end
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      body.push_back(fid[7:0]);
      if (v2) begin
         body.push_back(fid[15:8]);
         body.push_back(fid[23:16]);
      end
      repeat (plen) body.push_back(8'($urandom));
      crc = CRC_SEED;
      for (int i = 1; i < body.size(); i++) crc = crc_step(crc, body[i]);
      crc = crc_step(crc, fold_for(fid));
      if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      if (v2 && incompat[0]) repeat (SIG_BYTES) body.push_back(8'($urandom));
      wr_at = mid_write ? $urandom_range(1, body.size() - 1) : -1;
      foreach (body[i]) begin
         if (i == wr_at) begin
            w.func        = FUNC_TABLE;
            w.frame_byte  = 8'($urandom);
            w.entry_index = fid[8:0];
            w.entry_known = 1'b1;
            w.entry_extra = 8'($urandom);
            offer(w);
            table_writes++;
         end
         send_byte(body[i]);
      end
   endtask

   // mostly well-formed frames, some table loads and stray bytes
   task automatic random_traffic(input int stop_at);
      int          roll, sel, plen;
      logic        v2;
      logic [7:0]  lead, incompat;
      logic [23:0] id;
      while (sent_count < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            write_entry($urandom_range(1) ? 9'($urandom_range(255))
                                          : 9'($urandom_range(TABLE_DEPTH - 1)),
                        $urandom_range(3) != 0, 8'($urandom));
         end else if (roll < 14) begin
            // stray bytes knock the framing out of step
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
         end else begin
            sel = $urandom_range(99);
            if (sel < 55 && known_ids.size() > 0)
               id = 24'(known_ids[$urandom_range(known_ids.size() - 1)]);
            else if (sel < 85) id = 24'($urandom_range(TABLE_DEPTH - 1));
            else id = 24'($urandom);
            v2 = 1'($urandom);
            lead = ($urandom_range(1) == 0) ? 8'hFE : 8'($urandom);
            if (lead == MAGIC_V2) lead = 8'hFE;
            incompat = 8'($urandom);
            incompat[0] = ($urandom_range(3) == 0);
            plen = ($urandom_range(99) < 3) ? $urandom_range(200, 255) : $urandom_range(24);
            send_frame(v2, lead, incompat, 8'(plen), id, $urandom_range(99) < 15,
                       $urandom_range(99) < 6);
         end
      end
   endtask

   // result side: random stalls, and one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL mavlink_frame_checker_unit");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // table entries at both ends of the id range, one cleared
      write_entry(9'd0, 1'b1, 8'h32);
      write_entry(9'd511, 1'b1, 8'hFF);
      write_entry(9'd300, 1'b1, 8'h00);
      write_entry(9'd77, 1'b0, 8'hA5);
      // v1 frames: usual start byte and an arbitrary one, good and broken crc
      send_frame(1'b0, 8'hFE, 8'h00, 8'd0, 24'd0, 1'b0, 1'b0);
      send_frame(1'b0, 8'h00, 8'h00, 8'd0, 24'd0, 1'b1, 1'b0);
      // v2 at the top table entry, then a signed frame
      send_frame(1'b1, 8'h00, 8'h00, 8'd0, 24'd511, 1'b0, 1'b0);
      send_frame(1'b1, 8'h00, 8'h01, 8'd3, 24'd300, 1'b0, 1'b0);
      // id past the table gets a solved extra; broken crc on an unknown id
      send_frame(1'b1, 8'h00, 8'h00, 8'd1, 24'hFFFFFF, 1'b0, 1'b0);
      send_frame(1'b1, 8'h00, 8'h00, 8'd2, 24'd77, 1'b1, 1'b0);
      // table write inside a frame must not take effect
      send_frame(1'b0, 8'hFF, 8'h00, 8'd4, 24'd200, 1'b0, 1'b1);
      send_frame(1'b0, 8'hFE, 8'h00, 8'd0, 24'd200, 1'b0, 1'b0);
      // longest payloads, every flag bit set on the v2 one
      send_frame(1'b1, 8'h00, 8'hFF, 8'd255, 24'd0, 1'b0, 1'b0);
      send_frame(1'b0, 8'hFF, 8'h00, 8'd255, 24'd511, 1'b1, 1'b0);

      // three idling phases, the last one opening with a long result hold-off
      base = sent_count;
      random_traffic(base + RANDOM_ITEMS / 3);
      send_idle_pct = 76;
      recv_idle_pct = 30;
      random_traffic(base + 2 * RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_pending = 1'b1;
      random_traffic(base + RANDOM_ITEMS);

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions (%0d table writes) over %0d cycles",
               sent_count, table_writes, cycle_count);
      $display("frame results checked: %0d ok, %0d bad crc, %0d unknown id, %0d missing",
               frames_ok, frames_bad, frames_unknown, outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS mavlink_frame_checker_unit");
      else
         $display("FAIL mavlink_frame_checker_unit");
      $finish;
   end

endmodule
